@@ rtl/sensor_frame_deframer_macros.svh @@
// Assertion macros shared by the deframer checker.
`ifndef SENSOR_FRAME_DEFRAMER_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_MACROS_SVH

// Generic clocked property with async active-low reset masking.
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Signal holds its value on the cycle after cond was seen.
`define SFD_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
// Shared constants and types for the sensor frame deframer.
package sfd_pkg;

  localparam int unsigned FRAME_LENGTH = 5;
  localparam int unsigned PhaseW       = 3;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [ByteW-1:0] HeadReset   = 8'h55;
  localparam logic [ByteW-1:0] FormatReset = 8'hB1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD   = 1'b0,
    CFG_FORMAT = 1'b1
  } cfg_idx_e;

  // Per-byte outcome of the framing logic.
  typedef struct packed {
    logic             fire;    // this byte closes a frame
    logic [ByteW-1:0] value;
    logic             status;  // 1: checksum mismatch
  } frame_res_t;

endpackage

@@ rtl/sfd_byte_if.sv @@
// Valid/ready channel carrying one received serial byte.
interface sfd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sfd_result_if.sv @@
// Valid/ready channel carrying one decoded frame result.
interface sfd_result_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::ByteW-1:0] sensor_value;
  logic                      frame_status;

  modport source (output valid, output sensor_value, output frame_status, input ready);
  modport sink   (input valid, input sensor_value, input frame_status, output ready);
endinterface

@@ rtl/sfd_frame_fsm.sv @@
// Frame phase tracker, running checksum and value capture.
module sfd_frame_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [sfd_pkg::ByteW-1:0] rx_byte_i,
  input  logic [sfd_pkg::ByteW-1:0] head_i,
  input  logic [sfd_pkg::ByteW-1:0] format_i,
  output sfd_pkg::frame_res_t       res_o
);

  typedef enum logic [sfd_pkg::PhaseW-1:0] {
    PH_HUNT  = 3'd0,
    PH_HEAD  = 3'd1,
    PH_VALUE = 3'd2,
    PH_SPARE = 3'd3,
    PH_CHECK = sfd_pkg::PhaseW'(sfd_pkg::FRAME_LENGTH - 1)
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [sfd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [sfd_pkg::ByteW-1:0] value_q, value_d;
  logic [sfd_pkg::ByteW-1:0] expect_sum;
  phase_e                    hunt_phase;

  assign expect_sum = (~sum_q) + 8'd1;
  assign hunt_phase = (rx_byte_i == head_i) ? PH_HEAD : PH_HUNT;

  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    value_d      = value_q;
    res_o.fire   = 1'b0;
    res_o.value  = value_q;
    res_o.status = (rx_byte_i != expect_sum);
    case (phase_q)
      PH_HEAD: begin
        // format match wins even when head and format are equal
        if (rx_byte_i == format_i) begin
          sum_d   = rx_byte_i;
          phase_d = PH_VALUE;
        end else begin
          phase_d = hunt_phase;
        end
      end
      PH_VALUE: begin
        value_d = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = PH_SPARE;
      end
      PH_SPARE: begin
        sum_d   = sum_q + rx_byte_i;
        phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        res_o.fire = 1'b1;
        phase_d    = PH_HUNT;
      end
      default: begin
        phase_d = hunt_phase;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= '0;
      value_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      value_q <= value_d;
    end
  end

endmodule

@@ rtl/sensor_frame_deframer.sv @@
// Top level of the serial sensor frame deframer.
//
//  channel     dir  payload                      role
//  byte_in     in   rx_byte[7:0]                 received serial bytes, arrival order
//  result_out  out  sensor_value[7:0], status    one transfer per completed frame
//  cfg_*       in   idx[0], wdata[7:0]           head / format byte registers
//
// Cycles: a byte is taken into the input register, then classified by the
// frame tracker and, on the checksum byte, written to the result register;
// one byte per cycle sustained unless a checksum byte waits on a full result register.
// The single frame-tracker update per byte sets that rate.
// Reset: frame tracker back to hunting, head 0x55, format 0xB1, both stages empty.
// Stalls: only a checksum byte waits on a full result register; other bytes
// keep flowing, so byte_in.ready drops only while a result is pending.
module sensor_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfd_byte_if.sink                    byte_in,
  sfd_result_if.source                result_out,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_wdata_i
);

  // Config registers
  logic [sfd_pkg::ByteW-1:0] head_q, format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= sfd_pkg::HeadReset;
      format_q <= sfd_pkg::FormatReset;
    end else if (cfg_we_i) begin
      case (sfd_pkg::cfg_idx_e'(cfg_idx_i))
        sfd_pkg::CFG_HEAD:   head_q   <= cfg_wdata_i;
        sfd_pkg::CFG_FORMAT: format_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register stage
  logic                      in_valid_q;
  logic [sfd_pkg::ByteW-1:0] in_byte_q;
  logic                      advance;
  sfd_pkg::frame_res_t       res;

  // Result register
  logic                      out_valid_q;
  logic [sfd_pkg::ByteW-1:0] out_value_q;
  logic                      out_status_q;
  logic                      out_free;

  assign out_free      = !out_valid_q || result_out.ready;
  // a byte that closes no frame never waits on the result side
  assign advance       = in_valid_q && (!res.fire || out_free);
  assign byte_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte_q <= byte_in.rx_byte;
    end
  end

  sfd_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .head_i    (head_q),
    .format_i  (format_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res.fire) begin
      out_value_q  <= res.value;
      out_status_q <= res.status;
    end
  end

  assign result_out.valid        = out_valid_q;
  assign result_out.sensor_value = out_value_q;
  assign result_out.frame_status = out_status_q;

endmodule

@@ rtl/sfd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`include "sensor_frame_deframer_macros.svh"

module sfd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [sfd_pkg::ByteW-1:0] out_value_i,
  input logic                      out_status_i
);

  `SFD_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result valid dropped while stalled")
  `SFD_ASSERT_HOLD(a_out_payload_held, clk_i, rst_ni, out_valid_i && !out_ready_i, {out_value_i, out_status_i}, "result payload changed while stalled")
  // input only backs up behind a stalled result
  `SFD_ASSERT(a_in_stall_cause, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without pending result")
  // a fresh result always comes from a byte transfer via the input register and the result register
  `SFD_ASSERT(a_result_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without matching byte transfer")

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_in.valid),
  .in_ready_i   (byte_in.ready),
  .out_valid_i  (result_out.valid),
  .out_ready_i  (result_out.ready),
  .out_value_i  (result_out.sensor_value),
  .out_status_i (result_out.frame_status)
);
